FILE: src/pfa_pkg.sv
// ---------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// Command, error and status codes, queue entry and per-page record layouts.
// ---------------------------------------------------------------------------
package pfa_pkg;

    // field widths
    localparam int PAGE_W = 14;
    localparam int CMD_W  = 3;
    localparam int ERR_W  = 3;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 16;
    localparam int FREE_W = 15;
    localparam int RSV_W  = 15;
    localparam int SKIP_W = 14;
    localparam int CFG_W  = 15;
    localparam int CFG_IDX_W = 1;

    // default geometry
    localparam int NUM_PAGES_DEF = 16384;
    localparam int Q_DEPTH_DEF   = 2;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIPPED  = 1'd1;
    localparam logic [RSV_W-1:0]     RESERVED_RST = 15'd1024;
    localparam logic [SKIP_W-1:0]    SKIPPED_RST  = 14'd16383;

    // commands
    localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INCREF = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DECREF = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd5;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_IN_USE    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd3;
    localparam logic [ERR_W-1:0] ERR_RANGE     = 3'd4;
    localparam logic [ERR_W-1:0] ERR_DOUBLE    = 3'd5;

    // page status codes
    localparam logic [STAT_W-1:0] STAT_USED   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LISTED = 2'd2;

    // class of a command, settled in the front end
    typedef enum logic [1:0] {
        OP_INIT,
        OP_ALLOC,
        OP_PAGE,
        OP_RANGE
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] page;
    } q_entry_t;

    // back end to front end
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_stat_t;

    typedef struct packed {
        logic [RSV_W-1:0]  reserved;
        logic [SKIP_W-1:0] skipped;
    } cfg_t;

    // per-page record
    typedef struct packed {
        logic             on_list;
        logic [CNT_W-1:0] count;
    } pinfo_t;

    typedef struct packed {
        logic [FREE_W-1:0] free_cnt;
        logic [CNT_W-1:0]  count;
        logic [STAT_W-1:0] status;
        logic [ERR_W-1:0]  err;
        logic [PAGE_W-1:0] page;
    } result_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT_WALK,
        S_INIT_SKIP,
        S_ALLOC_STK,
        S_ALLOC_INFO,
        S_PG_EX
    } state_t;

    function automatic logic [STAT_W-1:0] status_of(input pinfo_t info);
        logic [STAT_W-1:0] st;
        if (info.count != '0) begin
            st = STAT_USED;
        end else if (info.on_list) begin
            st = STAT_LISTED;
        end else begin
            st = STAT_ZERO;
        end
        return st;
    endfunction

endpackage

FILE: src/pfa_ram.sv
// ---------------------------------------------------------------------------
// pfa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/pfa_front.sv
// ---------------------------------------------------------------------------
// pfa_front: command intake and classification
// Accepts input beats, sorts each into a command class and holds it in a
// short queue until the back end takes it.
// ---------------------------------------------------------------------------
module pfa_front
    import pfa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int Q_DEPTH   = Q_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CMD_W-1:0]  in_cmd,
    input  logic [PAGE_W-1:0] in_page,
    input  back_stat_t        bstat,
    output logic              q_valid,
    output q_entry_t          q_head
);

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    q_entry_t         q_mem_reg [Q_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   cnt_reg, cnt_next;
    q_entry_t         entry;
    logic             push;

    // classify the incoming command
    always_comb begin
        entry.cmd  = in_cmd;
        entry.page = in_page;
        if (in_cmd == CMD_INIT) begin
            entry.kind = OP_INIT;
        end else if (in_cmd == CMD_ALLOC) begin
            entry.kind = OP_ALLOC;
        end else if (in_cmd > CMD_QUERY || 32'(in_page) >= NUM_PAGES) begin
            entry.kind = OP_RANGE;
        end else begin
            entry.kind = OP_PAGE;
        end
    end

    assign s_tready = (cnt_reg != QCW'(Q_DEPTH)) && !bstat.clearing;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign q_head   = q_mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (bstat.pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !bstat.pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && bstat.pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

FILE: src/pfa_back.sv
// ---------------------------------------------------------------------------
// pfa_back: allocator execution engine
// Holds the page record RAM and the free stack RAM, runs the clearing pass,
// the init walk and each command's read-modify-write, and keeps the result
// register.
// ---------------------------------------------------------------------------
module pfa_back
    import pfa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  q_entry_t   q_head,
    output back_stat_t bstat,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    localparam int PAW = $clog2(NUM_PAGES);
    localparam int TW  = $clog2(NUM_PAGES + 1);
    localparam int IW  = $bits(pinfo_t);

    state_t          state_reg, state_next;
    logic [PAW-1:0]  idx_reg, idx_next;
    logic [TW-1:0]   top_reg, top_next;
    q_entry_t        op_reg, op_next;
    logic [PAW-1:0]  alloc_pg_reg, alloc_pg_next;
    logic            out_valid_reg, out_valid_next;
    result_t         out_reg, out_next;

    // RAM ports
    logic            info_we;
    logic [PAW-1:0]  info_waddr, info_raddr;
    pinfo_t          info_wdata, info_rdata;
    logic [IW-1:0]   info_rdata_raw;
    logic            stk_we;
    logic [PAW-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    // working signals
    logic            out_load, out_free, last_idx, walk_adv, do_push, has_room;
    logic [TW-1:0]   top_m1;
    logic [PAW-1:0]  op_pg;
    pinfo_t          nw;
    result_t         res;

    pfa_ram #(.WIDTH(IW), .DEPTH(NUM_PAGES)) u_info_ram (
        .aclk  (aclk),
        .we    (info_we),
        .waddr (info_waddr),
        .wdata (info_wdata),
        .raddr (info_raddr),
        .rdata (info_rdata_raw)
    );
    assign info_rdata = pinfo_t'(info_rdata_raw);

    pfa_ram #(.WIDTH(PAW), .DEPTH(NUM_PAGES)) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign last_idx  = (idx_reg == PAW'(NUM_PAGES - 1));
    assign top_m1    = top_reg - 1'b1;
    assign op_pg     = PAW'(op_reg.page);
    assign has_room  = (32'(top_reg) < NUM_PAGES);
    assign out_free  = !out_valid_reg || out_ready;

    // next state, RAM control and result
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        top_next       = top_reg;
        op_next        = op_reg;
        alloc_pg_next  = alloc_pg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        info_we        = 1'b0;
        info_waddr     = idx_reg;
        info_wdata     = '0;
        info_raddr     = idx_reg;
        stk_we         = 1'b0;
        stk_waddr      = top_reg[PAW-1:0];
        stk_wdata      = idx_reg;
        stk_raddr      = top_m1[PAW-1:0];
        bstat.pop      = 1'b0;
        bstat.clearing = (state_reg == S_CLEAR);
        out_load       = 1'b0;
        walk_adv       = 1'b0;
        do_push        = 1'b0;
        nw             = info_rdata;
        res            = '0;

        case (state_reg)
            // zero every page record after reset
            S_CLEAR: begin
                info_we = 1'b1;
                if (last_idx) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // take the next command when the result register can take a beat
            S_IDLE: begin
                if (q_valid && out_free) begin
                    bstat.pop = 1'b1;
                    op_next   = q_head;
                    case (q_head.kind)
                        OP_INIT: begin
                            top_next   = '0;
                            idx_next   = '0;
                            state_next = S_INIT_WALK;
                        end
                        OP_ALLOC: begin
                            if (top_reg == '0) begin
                                out_load = 1'b1;
                                res.err  = ERR_EMPTY;
                            end else begin
                                top_next   = top_m1;
                                state_next = S_ALLOC_STK;
                            end
                        end
                        OP_PAGE: begin
                            info_raddr = PAW'(q_head.page);
                            state_next = S_PG_EX;
                        end
                        default: begin
                            out_load = 1'b1;
                            res.page = q_head.page;
                            res.err  = ERR_RANGE;
                        end
                    endcase
                end
            end

            // one page per cycle, skip adds S_INIT_SKIP: reserved, skipped or pushed
            S_INIT_WALK: begin
                if (32'(idx_reg) < 32'(cfg.reserved)) begin
                    info_we    = 1'b1;
                    info_wdata = '{on_list: 1'b0, count: CNT_W'(1)};
                    walk_adv   = 1'b1;
                end else if (32'(idx_reg) == 32'(cfg.skipped)) begin
                    state_next = S_INIT_SKIP;
                end else begin
                    info_we    = 1'b1;
                    info_wdata = '{on_list: has_room, count: '0};
                    stk_we     = has_room;
                    if (has_room) begin
                        top_next = top_reg + 1'b1;
                    end
                    walk_adv = 1'b1;
                end
            end

            // skipped page keeps its count, leaves the list
            S_INIT_SKIP: begin
                info_we    = 1'b1;
                info_wdata = '{on_list: 1'b0, count: info_rdata.count};
                walk_adv   = 1'b1;
                state_next = S_INIT_WALK;
            end

            // popped page number is out, fetch its record
            S_ALLOC_STK: begin
                alloc_pg_next = stk_rdata;
                info_raddr    = stk_rdata;
                state_next    = S_ALLOC_INFO;
            end

            S_ALLOC_INFO: begin
                nw.on_list = 1'b0;
                info_we    = 1'b1;
                info_waddr = alloc_pg_reg;
                info_wdata = nw;
                out_load   = 1'b1;
                res.page   = PAGE_W'(alloc_pg_reg);
                res.status = status_of(nw);
                res.count  = nw.count;
                state_next = S_IDLE;
            end

            // read-modify-write of one page record
            S_PG_EX: begin
                res.err = ERR_OK;
                case (op_reg.cmd)
                    CMD_FREE: begin
                        if (info_rdata.on_list) begin
                            res.err = ERR_DOUBLE;
                        end else if (info_rdata.count != '0) begin
                            res.err = ERR_IN_USE;
                        end else begin
                            do_push = 1'b1;
                        end
                    end
                    CMD_INCREF: begin
                        if (info_rdata.count != '1) begin
                            nw.count = info_rdata.count + 1'b1;
                        end
                    end
                    CMD_DECREF: begin
                        if (info_rdata.count == '0) begin
                            res.err = ERR_UNDERFLOW;
                        end else begin
                            nw.count = info_rdata.count - 1'b1;
                            do_push  = (nw.count == '0) && !info_rdata.on_list;
                        end
                    end
                    default: begin
                    end
                endcase
                if (do_push && has_room) begin
                    nw.on_list = 1'b1;
                    stk_we     = 1'b1;
                    stk_wdata  = op_pg;
                    top_next   = top_reg + 1'b1;
                end
                info_we    = 1'b1;
                info_waddr = op_pg;
                info_wdata = nw;
                out_load   = 1'b1;
                res.page   = op_reg.page;
                res.status = status_of(nw);
                res.count  = nw.count;
                state_next = S_IDLE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // end of the init walk returns the init result
        if (walk_adv) begin
            if (last_idx) begin
                idx_next   = '0;
                out_load   = 1'b1;
                state_next = S_IDLE;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end

        res.free_cnt = (32'(top_next) > 32'h7FFF) ? '1 : FREE_W'(top_next);
        out_next     = out_load ? res : out_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        alloc_pg_reg <= alloc_pg_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: src/page_frame_allocator_refcount.sv
// ---------------------------------------------------------------------------
// page_frame_allocator_refcount: physical page frame allocator
// Per-page reference counts, a LIFO free stack and an on-list bit per page.
// ---------------------------------------------------------------------------
// After reset the block clears its page record RAM, one page per cycle;
// s_tready stays low during that pass. Commands then run one at a time in
// the back end: query, free, incref and decref do one record read, then one
// record write; alloc does a stack read, then a record read-modify-write; a
// range error or an alloc on an empty stack returns from the dispatch state;
// and init does the dispatch, then one page per cycle, plus an extra step
// when the skipped page lies at or above reserved_pages.
// Every record access goes through the registered read port of the page
// record RAM. A two-entry command queue keeps s_tready up while a result
// waits on m_tready, until it holds two commands.
module page_frame_allocator_refcount
    import pfa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // command channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [13:0] page_index
    input  logic [CMD_W-1:0]     s_tuser,   // [2:0] cmd
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,   // [13:0] result_page, [16:14] error_code,
                                            // [18:17] page_status, [34:19] ref_count,
                                            // [49:35] free_count
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [RSV_W-1:0]  reserved_reg;
    logic [SKIP_W-1:0] skipped_reg;
    cfg_t              cfg;
    back_stat_t        bstat;
    logic              q_valid;
    q_entry_t          q_head;
    result_t           res;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg <= RESERVED_RST;
            skipped_reg  <= SKIPPED_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_RESERVED: reserved_reg <= cfg_wdata[RSV_W-1:0];
                CFG_SKIPPED:  skipped_reg  <= cfg_wdata[SKIP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.reserved = reserved_reg;
    assign cfg.skipped  = skipped_reg;

    pfa_front #(.NUM_PAGES(NUM_PAGES), .Q_DEPTH(Q_DEPTH_DEF)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (s_tuser),
        .in_page  (s_tdata[PAGE_W-1:0]),
        .bstat    (bstat),
        .q_valid  (q_valid),
        .q_head   (q_head)
    );

    pfa_back #(.NUM_PAGES(NUM_PAGES)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .bstat     (bstat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // result beat packing, zero padded to whole bytes
    assign m_tdata = {6'b0, res.free_cnt, res.count, res.status, res.err, res.page};

endmodule
